// ----- rtl/pv2hp_pkg.sv -----
// Types, constants and helpers for the PROXY v2 header parser.
// No dependencies; imported by every module of the block.
package pv2hp_pkg;

  localparam int unsigned IdxW   = 17;
  localparam int unsigned SigLen = 12;

  localparam logic [IdxW-1:0] IDX_MAX   = '1;
  localparam logic [IdxW-1:0] FIXED_LEN = IdxW'(16);

  localparam logic [7:0] VERCMD_PROXY = 8'h21;
  localparam logic [7:0] FAM_V4_TCP   = 8'h11;
  localparam logic [7:0] FAM_V4_UDP   = 8'h12;
  localparam logic [7:0] FAM_V6_TCP   = 8'h21;
  localparam logic [7:0] FAM_V6_UDP   = 8'h22;

  localparam logic [7:0] SIG_BYTES [SigLen] = '{
    8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D,
    8'h0A, 8'h51, 8'h55, 8'h49, 8'h54, 8'h0A
  };

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SIG = 3'd1,
    ST_BAD_VER = 3'd2,
    ST_BAD_FAM = 3'd3,
    ST_BAD_LEN = 3'd4,
    ST_TRUNC   = 3'd5
  } pv2hp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } pv2hp_in_t;

  typedef struct packed {
    pv2hp_status_e   status;
    logic            is_ipv6;
    logic [63:0]     src_addr_hi;
    logic [63:0]     src_addr_lo;
    logic [63:0]     dst_addr_hi;
    logic [63:0]     dst_addr_lo;
    logic [15:0]     src_port_out;
    logic [15:0]     dst_port_out;
    logic [IdxW-1:0] header_length;
  } pv2hp_out_t;

  function automatic logic is_fam_v4(input logic [7:0] f);
    return (f == FAM_V4_TCP) || (f == FAM_V4_UDP);
  endfunction

  function automatic logic is_fam_v6(input logic [7:0] f);
    return (f == FAM_V6_TCP) || (f == FAM_V6_UDP);
  endfunction

endpackage

// ----- rtl/pv2hp_parse.sv -----
// Per-packet parse state and the byte decode: signature, version, family,
// length and address capture. Depends on pv2hp_pkg.
module pv2hp_parse import pv2hp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  pv2hp_in_t  byte_i,
  output logic       res_valid_o,
  output pv2hp_out_t res_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic            sent_q, sent_d;
  logic [7:0]      fam_q, fam_d;
  logic [15:0]     rlen_q, rlen_d;
  logic [63:0]     src_hi_q, src_hi_d, src_lo_q, src_lo_d;
  logic [63:0]     dst_hi_q, dst_hi_d, dst_lo_q, dst_lo_d;
  logic [15:0]     sport_q, sport_d, dport_q, dport_d;
  logic            hit;
  pv2hp_status_e   st;
  logic [7:0]      b;

  assign b = byte_i.data_byte;

  always_comb begin
    idx_d    = idx_q;
    sent_d   = sent_q;
    fam_d    = fam_q;
    rlen_d   = rlen_q;
    src_hi_d = src_hi_q;
    src_lo_d = src_lo_q;
    dst_hi_d = dst_hi_q;
    dst_lo_d = dst_lo_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    hit      = 1'b0;
    st       = ST_OK;
    res_o    = '0;

    if (!sent_q) begin
      if (idx_q < IdxW'(SigLen)) begin
        if (b != SIG_BYTES[idx_q[3:0]]) begin
          hit = 1'b1;
          st  = ST_BAD_SIG;
        end
      end else if (idx_q == IdxW'(12)) begin
        if (b != VERCMD_PROXY) begin
          hit = 1'b1;
          st  = ST_BAD_VER;
        end
      end else if (idx_q == IdxW'(13)) begin
        fam_d = b;
        if (!is_fam_v4(b) && !is_fam_v6(b)) begin
          hit = 1'b1;
          st  = ST_BAD_FAM;
        end
      end else if (idx_q == IdxW'(14)) begin
        rlen_d = {b, 8'h00};
      end else if (idx_q == IdxW'(15)) begin
        rlen_d = {rlen_q[15:8], b};
        if (is_fam_v4(fam_q) ? (rlen_d < 16'd12) : (rlen_d < 16'd36)) begin
          hit = 1'b1;
          st  = ST_BAD_LEN;
        end
      end else begin
        // address block: starts at byte 16; case labels are absolute byte indices
        if (is_fam_v4(fam_q)) begin
          case (idx_q) inside
            [IdxW'(16):IdxW'(19)]: src_lo_d = {src_lo_q[55:0], b};
            [IdxW'(20):IdxW'(23)]: dst_lo_d = {dst_lo_q[55:0], b};
            [IdxW'(24):IdxW'(25)]: sport_d  = {sport_q[7:0], b};
            [IdxW'(26):IdxW'(27)]: dport_d  = {dport_q[7:0], b};
            default: ;
          endcase
        end else begin
          case (idx_q) inside
            [IdxW'(16):IdxW'(23)]: src_hi_d = {src_hi_q[55:0], b};
            [IdxW'(24):IdxW'(31)]: src_lo_d = {src_lo_q[55:0], b};
            [IdxW'(32):IdxW'(39)]: dst_hi_d = {dst_hi_q[55:0], b};
            [IdxW'(40):IdxW'(47)]: dst_lo_d = {dst_lo_q[55:0], b};
            [IdxW'(48):IdxW'(49)]: sport_d  = {sport_q[7:0], b};
            [IdxW'(50):IdxW'(51)]: dport_d  = {dport_q[7:0], b};
            default: ;
          endcase
        end
        if (idx_q == (FIXED_LEN - IdxW'(1)) + {1'b0, rlen_q}) begin
          hit = 1'b1;
          st  = ST_OK;
        end
      end

      if (!hit && byte_i.last_byte) begin
        hit = 1'b1;
        st  = ST_TRUNC;
      end
      sent_d = hit;
      if (idx_q != IDX_MAX) begin
        idx_d = idx_q + IdxW'(1);
      end
    end

    res_o.status = st;
    if (st == ST_OK) begin
      res_o.is_ipv6       = is_fam_v6(fam_d);
      res_o.src_addr_hi   = src_hi_d;
      res_o.src_addr_lo   = src_lo_d;
      res_o.dst_addr_hi   = dst_hi_d;
      res_o.dst_addr_lo   = dst_lo_d;
      res_o.src_port_out  = sport_d;
      res_o.dst_port_out  = dport_d;
      res_o.header_length = FIXED_LEN + {1'b0, rlen_d};
    end

    // final byte rearms for the next packet
    if (byte_i.last_byte) begin
      idx_d    = '0;
      sent_d   = 1'b0;
      fam_d    = '0;
      rlen_d   = '0;
      src_hi_d = '0;
      src_lo_d = '0;
      dst_hi_d = '0;
      dst_lo_d = '0;
      sport_d  = '0;
      dport_d  = '0;
    end
  end

  assign res_valid_o = step_i && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      sent_q   <= 1'b0;
      fam_q    <= '0;
      rlen_q   <= '0;
      src_hi_q <= '0;
      src_lo_q <= '0;
      dst_hi_q <= '0;
      dst_lo_q <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
    end else if (step_i) begin
      idx_q    <= idx_d;
      sent_q   <= sent_d;
      fam_q    <= fam_d;
      rlen_q   <= rlen_d;
      src_hi_q <= src_hi_d;
      src_lo_q <= src_lo_d;
      dst_hi_q <= dst_hi_d;
      dst_lo_q <= dst_lo_d;
      sport_q  <= sport_d;
      dport_q  <= dport_d;
    end
  end

  // once a packet has reported, nothing more until its final byte
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && sent_q && !byte_i.last_byte |-> !res_valid_o)
    else $error("second result within one packet");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != ST_OK |->
      res_o.header_length == '0 && res_o.src_addr_lo == '0 && res_o.dst_port_out == '0)
    else $error("error result carries nonzero fields");

  a_idx_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !sent_q && !byte_i.last_byte && idx_q != IDX_MAX |=>
      idx_q == $past(idx_q) + IdxW'(1))
    else $error("byte index failed to advance");

endmodule

// ----- rtl/pv2hp_out.sv -----
// Result register toward the output channel.
// Depends on pv2hp_pkg.
module pv2hp_out import pv2hp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pv2hp_out_t res_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pv2hp_out_t out_data_o
);

  logic       valid_q;
  pv2hp_out_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/proxy_v2_header_parser_top.sv -----
// PROXY v2 header parser: top level with the input word register.
// Depends on pv2hp_pkg, pv2hp_parse and pv2hp_out.
//
// Input channel: one packet byte per word, last_byte set on the final byte.
// Output channel: at most one result word per packet, carrying status, the
// binary addresses and ports, and the total header length.
// A word enters the input register, is decoded against the packet state
// while it waits there, and lands in the result register when the input
// register advances; the output channel is driven from that register.
// Throughput is one byte per cycle while the output side is ready; the
// input register advances whenever the result register is empty or drained
// in the same cycle.
// When the receiver stalls with a result pending, the input register holds
// one byte and in_ready_o drops until the result is taken.
// Reset clears the packet state, so the next byte is signature byte 0.
// Bytes after a reported result are consumed silently up to the final byte,
// which rearms the parser.
module proxy_v2_header_parser_top import pv2hp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pv2hp_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pv2hp_out_t out_data_o
);

  logic       in_valid_q;
  pv2hp_in_t  in_data_q;
  logic       advance;
  logic       res_valid;
  pv2hp_out_t res;

  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  pv2hp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pv2hp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
